[rtl/mlsp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mlsp_pkg
// Shared types and codes for the mode-select parameter list parser.
// ----------------------------------------------------------------------------
package mlsp_pkg;

  // Parse phases
  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_DESC   = 2'd1;
  localparam logic [1:0] PH_HEAD   = 2'd2;
  localparam logic [1:0] PH_BODY   = 2'd3;

  // Summary status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_DESC_OVF  = 3'd2;
  localparam logic [2:0] ST_TRUNC     = 3'd3;
  localparam logic [2:0] ST_OVERLONG  = 3'd4;

  // Result kinds
  localparam logic KIND_PAGE    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam int unsigned OUT_DATA_W = 104;

  typedef struct packed {
    logic        record_kind;
    logic        final_result;
    logic [2:0]  status;
    logic [5:0]  mode_code;
    logic [7:0]  body_len;
    logic [7:0]  body_offset;
    logic [4:0]  page_count;
    logic [7:0]  media_kind;
    logic [7:0]  dev_spec;
    logic [7:0]  desc_len;
    logic [23:0] block_total;
    logic [23:0] block_bytes;
  } mlsp_res_t;

endpackage : mlsp_pkg
`default_nettype wire

[rtl/mlsp_parser.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mlsp_parser
// Parse state and per-byte decode; yields up to two results per accepted item.
// ----------------------------------------------------------------------------
module mlsp_parser
  import mlsp_pkg::*;
#(
  parameter int unsigned PAGE_LIMIT     = 16,
  parameter int unsigned MAX_LIST_BYTES = 255
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_accept,
  input  wire logic [7:0] data_byte,
  input  wire logic       last_byte,
  output mlsp_res_t       res0,
  output mlsp_res_t       res1,
  output logic [1:0]      res_cnt
);

  localparam int unsigned POS_W = $clog2(MAX_LIST_BYTES + 1);
  localparam int unsigned PG_W  = $clog2(PAGE_LIMIT + 1);

  logic [POS_W-1:0] pos_r,    pos_nxt;
  logic [1:0]       phase_r,  phase_nxt;
  logic [5:0]       code_r,   code_nxt;
  logic [7:0]       len_r,    len_nxt;
  logic [7:0]       start_r,  start_nxt;
  logic [7:0]       rem_r,    rem_nxt;
  logic [PG_W-1:0]  pages_r,  pages_nxt;
  logic [7:0]       med_r,    med_nxt;
  logic [7:0]       dev_r,    dev_nxt;
  logic [7:0]       desc_r,   desc_nxt;
  logic [23:0]      nblk_r,   nblk_nxt;
  logic [23:0]      blen_r,   blen_nxt;
  logic             seen_r,   seen_nxt;
  logic             ovl_r,    ovl_nxt;

  logic [15:0] pos16;
  logic        page_done;
  logic        emit;
  logic [2:0]  status;
  mlsp_res_t   rec;
  mlsp_res_t   sum;

  assign pos16 = 16'(pos_r);

  always_comb begin
    pos_nxt   = pos_r;
    phase_nxt = phase_r;
    code_nxt  = code_r;
    len_nxt   = len_r;
    start_nxt = start_r;
    rem_nxt   = rem_r;
    med_nxt   = med_r;
    dev_nxt   = dev_r;
    desc_nxt  = desc_r;
    nblk_nxt  = nblk_r;
    blen_nxt  = blen_r;
    seen_nxt  = seen_r;
    ovl_nxt   = ovl_r;
    page_done = 1'b0;

    if (pos_r == POS_W'(MAX_LIST_BYTES)) begin
      // past the list limit: drop the byte
      ovl_nxt = 1'b1;
    end else begin
      pos_nxt = pos_r + POS_W'(1);
      unique case (phase_r)
        PH_HEADER: begin
          if (pos16 == 16'd1) begin
            med_nxt = data_byte;
          end else if (pos16 == 16'd2) begin
            dev_nxt = data_byte;
          end else if (pos16 == 16'd3) begin
            desc_nxt  = data_byte;
            rem_nxt   = data_byte;
            phase_nxt = (data_byte == 8'd0) ? PH_HEAD : PH_DESC;
          end
        end
        PH_DESC: begin
          if (desc_r >= 8'd8) begin
            if (pos16 >= 16'd5 && pos16 <= 16'd7) begin
              nblk_nxt = {nblk_r[15:0], data_byte};
            end else if (pos16 >= 16'd9 && pos16 <= 16'd11) begin
              blen_nxt = {blen_r[15:0], data_byte};
            end
          end
          rem_nxt = rem_r - 8'd1;
          if (rem_r == 8'd1) begin
            phase_nxt = PH_HEAD;
          end
        end
        PH_HEAD: begin
          if (!seen_r) begin
            code_nxt  = data_byte[5:0];
            start_nxt = pos16[7:0] + 8'd2;
            seen_nxt  = 1'b1;
          end else begin
            seen_nxt = 1'b0;
            len_nxt  = data_byte;
            rem_nxt  = data_byte;
            if (data_byte == 8'd0) begin
              page_done = 1'b1;
            end else begin
              phase_nxt = PH_BODY;
            end
          end
        end
        PH_BODY: begin
          rem_nxt = rem_r - 8'd1;
          if (rem_r == 8'd1) begin
            page_done = 1'b1;
            phase_nxt = PH_HEAD;
          end
        end
      endcase
    end

    emit      = page_done && (pages_r != PG_W'(PAGE_LIMIT));
    pages_nxt = pages_r + PG_W'(emit);
  end

  // Summary status, overlong first
  always_comb begin
    priority if (ovl_nxt)               status = ST_OVERLONG;
    else if (phase_nxt == PH_HEADER)    status = ST_SHORT;
    else if (phase_nxt == PH_DESC)      status = ST_DESC_OVF;
    else if (phase_nxt == PH_BODY)      status = ST_TRUNC;
    else                                status = ST_OK;
  end

  always_comb begin
    rec              = '0;
    rec.record_kind  = KIND_PAGE;
    rec.final_result = !last_byte;
    rec.mode_code    = code_r;
    rec.body_len     = len_nxt;
    rec.body_offset  = start_r;
    rec.page_count   = 5'(pages_r);

    sum              = '0;
    sum.record_kind  = KIND_SUMMARY;
    sum.final_result = 1'b1;
    sum.status       = status;
    sum.page_count   = 5'(pages_nxt);
    if (status != ST_SHORT) begin
      sum.media_kind = med_nxt;
      sum.dev_spec   = dev_nxt;
      sum.desc_len   = desc_nxt;
    end
    if (status == ST_OK && desc_nxt >= 8'd8) begin
      sum.block_total = nblk_nxt;
      sum.block_bytes = blen_nxt;
    end

    if (emit) begin
      res0    = rec;
      res1    = sum;
      res_cnt = last_byte ? 2'd2 : 2'd1;
    end else begin
      res0    = sum;
      res1    = sum;
      res_cnt = {1'b0, last_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (in_accept && last_byte)) begin
      // end of list: back to the reset state
      pos_r   <= '0;
      phase_r <= PH_HEADER;
      code_r  <= '0;
      len_r   <= '0;
      start_r <= '0;
      rem_r   <= '0;
      pages_r <= '0;
      med_r   <= '0;
      dev_r   <= '0;
      desc_r  <= '0;
      nblk_r  <= '0;
      blen_r  <= '0;
      seen_r  <= 1'b0;
      ovl_r   <= 1'b0;
    end else if (in_accept) begin
      pos_r   <= pos_nxt;
      phase_r <= phase_nxt;
      code_r  <= code_nxt;
      len_r   <= len_nxt;
      start_r <= start_nxt;
      rem_r   <= rem_nxt;
      pages_r <= pages_nxt;
      med_r   <= med_nxt;
      dev_r   <= dev_nxt;
      desc_r  <= desc_nxt;
      nblk_r  <= nblk_nxt;
      blen_r  <= blen_nxt;
      seen_r  <= seen_nxt;
      ovl_r   <= ovl_nxt;
    end
  end

endmodule : mlsp_parser
`default_nettype wire

[rtl/mlsp_out_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mlsp_out_fifo
// Four-entry result queue; takes up to two results per cycle, gives one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module mlsp_out_fifo
  import mlsp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [1:0] push_cnt,
  input  wire mlsp_res_t  push0,
  input  wire mlsp_res_t  push1,
  output logic            room2,
  output logic            out_valid,
  input  wire logic       out_ready,
  output mlsp_res_t       out_res
);

  mlsp_res_t  mem_r [4];
  logic [1:0] head_r, head_nxt;
  logic [1:0] tail_r, tail_nxt;
  logic [2:0] cnt_r,  cnt_nxt;
  logic       pop;

  assign out_valid = (cnt_r != 3'd0);
  assign pop       = out_valid && out_ready;
  assign room2     = (cnt_r <= 3'd2);
  assign out_res   = mem_r[head_r];

  always_comb begin
    head_nxt = head_r + 2'(pop);
    tail_nxt = tail_r + push_cnt;
    cnt_nxt  = cnt_r + 3'(push_cnt) - 3'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem_r[tail_r] <= push0;
    end
    if (push_cnt == 2'd2) begin
      mem_r[tail_r + 2'd1] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule : mlsp_out_fifo
`default_nettype wire

[rtl/mode_select_list_parser.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mode_select_list_parser
// Walks a mode-select parameter list byte by byte, emitting page records and
// an end-of-list summary.
//
//  channel | dir | tdata                | tuser        | tlast
//  --------+-----+----------------------+--------------+------------------
//  in_     | in  | data_byte            | -            | last_byte
//  out_    | out | status..block_bytes  | record_kind  | final_result
//
// One byte is taken per cycle; its results land in a four-entry queue the
// cycle after. in_tready stays high while the queue has room for two results,
// so the input only stalls when the consumer holds back out_tready.
// A byte that ends a kept page (one within PAGE_LIMIT) on the final byte gives two results, record first.
// rst_n (synchronous) clears the parse state and empties the queue.
// ----------------------------------------------------------------------------
module mode_select_list_parser
  import mlsp_pkg::*;
#(
  parameter int unsigned PAGE_LIMIT     = 16,
  parameter int unsigned MAX_LIST_BYTES = 255
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [7:0]            in_tdata,   // [7:0] data_byte
  input  wire logic                  in_tlast,   // last_byte
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [2:0] status, [8:3] mode_code, [16:9] body_len, [24:17] body_offset,
  // [29:25] page_count, [37:30] media_kind, [45:38] dev_spec,
  // [53:46] desc_len, [77:54] block_total, [101:78] block_bytes, rest 0
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic                       out_tuser,  // record_kind
  output logic                       out_tlast   // final_result
);

  logic       accept;
  logic       room2;
  logic [1:0] res_cnt;
  logic [1:0] push_cnt;
  mlsp_res_t  res0;
  mlsp_res_t  res1;
  mlsp_res_t  head;

  assign in_tready = room2;
  assign accept    = in_tvalid && room2;
  assign push_cnt  = accept ? res_cnt : 2'd0;

  mlsp_parser #(
    .PAGE_LIMIT     (PAGE_LIMIT),
    .MAX_LIST_BYTES (MAX_LIST_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (accept),
    .data_byte (in_tdata),
    .last_byte (in_tlast),
    .res0      (res0),
    .res1      (res1),
    .res_cnt   (res_cnt)
  );

  mlsp_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .push0     (res0),
    .push1     (res1),
    .room2     (room2),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (head)
  );

  assign out_tuser = head.record_kind;
  assign out_tlast = head.final_result;
  assign out_tdata = {2'b00, head.block_bytes, head.block_total, head.desc_len,
                      head.dev_spec, head.media_kind, head.page_count,
                      head.body_offset, head.body_len, head.mode_code, head.status};

endmodule : mode_select_list_parser
`default_nettype wire

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Streams mode-select parameter lists into mode_select_list_parser and checks
// each page record and end-of-list summary against a local byte-level parser.
// Random lists are mostly well formed, with truncated, lone-code and overlong
// lists mixed in; both channels stall at random until the last third of the bytes.
// ----------------------------------------------------------------------------
module tb;
  import mlsp_pkg::*;

  localparam int unsigned PAGE_LIMIT     = 16;
  localparam int unsigned MAX_LIST_BYTES = 255;
  localparam int          LIST_ITEMS     = 1525;

  typedef struct {
    logic [7:0] data;
    logic       last;
    bit         hold;   // wait for every pending result before sending
  } list_byte_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;

  list_byte_t  list_bytes[$];
  logic [7:0]  list_draft[$];
  mlsp_res_t   expected_results[$];
  list_byte_t  next_byte;
  mlsp_res_t   want;

  bit          byte_taken;
  int          bytes_taken;
  int          total_bytes;
  int          send_idle_pct = 12;
  int          recv_idle_pct = 48;
  int          err_cnt;
  int          list_n;

  // parser state
  logic [8:0]  pos_cnt;
  logic [1:0]  phase;
  logic [5:0]  pg_code;
  logic [7:0]  pg_len;
  logic [7:0]  pg_start;
  logic [7:0]  remaining;
  logic [4:0]  pages_kept;
  logic [7:0]  hdr_medium;
  logic [7:0]  hdr_devparam;
  logic [7:0]  hdr_desclen;
  logic [23:0] blk_count;
  logic [23:0] blk_size;
  bit          code_pending;
  bit          too_long;

  mode_select_list_parser #(
    .PAGE_LIMIT     (PAGE_LIMIT),
    .MAX_LIST_BYTES (MAX_LIST_BYTES)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #10 clk = ~clk;

  task automatic clear_parser();
    pos_cnt      = '0;
    phase        = PH_HEADER;
    pg_code      = '0;
    pg_len       = '0;
    pg_start     = '0;
    remaining    = '0;
    pages_kept   = '0;
    hdr_medium   = '0;
    hdr_devparam = '0;
    hdr_desclen  = '0;
    blk_count    = '0;
    blk_size     = '0;
    code_pending = 1'b0;
    too_long     = 1'b0;
  endtask

  // Pages beyond PAGE_LIMIT are parsed but give no record.
  task automatic store_page(input logic is_last);
    mlsp_res_t r;
    if (pages_kept < PAGE_LIMIT) begin
      r              = '0;
      r.record_kind  = KIND_PAGE;
      r.final_result = !is_last;
      r.mode_code    = pg_code;
      r.body_len     = pg_len;
      r.body_offset  = pg_start;
      r.page_count   = pages_kept;
      expected_results.push_back(r);
      pages_kept = pages_kept + 5'd1;
    end
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic last);
    mlsp_res_t  r;
    logic [8:0] pos;
    pos = pos_cnt;
    if (pos >= MAX_LIST_BYTES) begin
      too_long = 1'b1;
    end else begin
      pos_cnt = pos + 9'd1;
      case (phase)
        PH_HEADER: begin
          if (pos == 9'd1) hdr_medium = b;
          else if (pos == 9'd2) hdr_devparam = b;
          else if (pos == 9'd3) begin
            hdr_desclen = b;
            remaining   = b;
            phase       = (b == 8'd0) ? PH_HEAD : PH_DESC;
          end
        end
        PH_DESC: begin
          if (hdr_desclen >= 8'd8) begin
            if (pos >= 9'd5 && pos <= 9'd7) blk_count = {blk_count[15:0], b};
            else if (pos >= 9'd9 && pos <= 9'd11) blk_size = {blk_size[15:0], b};
          end
          remaining = remaining - 8'd1;
          if (remaining == 8'd0) phase = PH_HEAD;
        end
        PH_HEAD: begin
          if (!code_pending) begin
            pg_code      = b[5:0];
            pg_start     = pos[7:0] + 8'd2;
            code_pending = 1'b1;
          end else begin
            code_pending = 1'b0;
            pg_len       = b;
            remaining    = b;
            if (b == 8'd0) store_page(last);
            else phase = PH_BODY;
          end
        end
        default: begin
          remaining = remaining - 8'd1;
          if (remaining == 8'd0) begin
            store_page(last);
            phase = PH_HEAD;
          end
        end
      endcase
    end

    if (last) begin
      r              = '0;
      r.record_kind  = KIND_SUMMARY;
      r.final_result = 1'b1;
      if (too_long) r.status = ST_OVERLONG;
      else begin
        case (phase)
          PH_HEADER: r.status = ST_SHORT;
          PH_DESC:   r.status = ST_DESC_OVF;
          PH_BODY:   r.status = ST_TRUNC;
          default:   r.status = ST_OK;
        endcase
      end
      r.page_count = pages_kept;
      if (r.status != ST_SHORT) begin
        r.media_kind = hdr_medium;
        r.dev_spec   = hdr_devparam;
        r.desc_len   = hdr_desclen;
      end
      if (r.status == ST_OK && hdr_desclen >= 8'd8) begin
        r.block_total = blk_count;
        r.block_bytes = blk_size;
      end
      expected_results.push_back(r);
      clear_parser();
    end
  endtask

  task automatic check_field(input string name, input logic [23:0] exp_val,
                             input logic [23:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, exp_val, act_val);
      err_cnt++;
    end
  endtask

  // Move the draft list into the send queue, marking its final byte.
  task automatic flush_list(input bit hold_first);
    list_byte_t it;
    for (int i = 0; i < list_draft.size(); i++) begin
      it.data = list_draft[i];
      it.last = (i == list_draft.size() - 1);
      it.hold = hold_first && (i == 0);
      list_bytes.push_back(it);
    end
  endtask

  // Build a random list: header, descriptor, pages, then maybe cut it short,
  // add a lone code byte, or pad it past the length limit.
  task automatic make_list(input bit stretch);
    int desc_n;
    int page_n;
    int body_n;
    int cut;
    int sel;
    int target;
    list_draft.delete();
    repeat (3) list_draft.push_back(8'($urandom));
    sel = $urandom_range(0, 99);
    if (sel < 30) desc_n = 0;
    else if (sel < 68) desc_n = 8;
    else if (sel < 83) desc_n = $urandom_range(1, 7);
    else if (sel < 97) desc_n = $urandom_range(9, 16);
    else desc_n = $urandom_range(17, 200);
    list_draft.push_back(8'(desc_n));
    repeat (desc_n) list_draft.push_back(8'($urandom));
    page_n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 19) : $urandom_range(0, 4);
    repeat (page_n) begin
      if (list_draft.size() < 220) begin
        body_n = ($urandom_range(0, 9) < 6) ? $urandom_range(0, 3) : $urandom_range(4, 12);
        list_draft.push_back(8'($urandom));
        list_draft.push_back(8'(body_n));
        repeat (body_n) list_draft.push_back(8'($urandom));
      end
    end
    if (stretch) begin
      target = MAX_LIST_BYTES + 1 + $urandom_range(0, 3);
      while (list_draft.size() < target) list_draft.push_back(8'($urandom));
    end else begin
      sel = $urandom_range(0, 99);
      if (sel < 25) begin
        cut = $urandom_range(1, list_draft.size());
        while (list_draft.size() > cut) void'(list_draft.pop_back());
      end else if (sel < 35) begin
        list_draft.push_back(8'($urandom));
      end
    end
  endtask

  // Sender and receiver: change inputs on the falling edge.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      out_tready <= 1'b0;
    end else begin
      if (!in_tvalid || byte_taken) begin
        if (list_bytes.size() != 0 &&
            !(list_bytes[0].hold && expected_results.size() != 0) &&
            $urandom_range(0, 99) >= send_idle_pct) begin
          next_byte = list_bytes.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= next_byte.data;
          in_tlast  <= next_byte.last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Monitor: predict on each accepted byte, check each accepted result.
  always @(posedge clk) begin
    if (!rst_n) begin
      byte_taken = 1'b0;
    end else begin
      byte_taken = in_tvalid && in_tready;
      if (byte_taken) begin
        parse_byte(in_tdata, in_tlast);
        bytes_taken++;
        if (bytes_taken < total_bytes / 3) begin
          send_idle_pct = 12;
          recv_idle_pct = 48;
        end else if (bytes_taken < 2 * total_bytes / 3) begin
          send_idle_pct = 48;
          recv_idle_pct = 12;
        end else begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      end
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result expected none actual %0h", $time, out_tdata);
          err_cnt++;
        end else begin
          want = expected_results.pop_front();
          check_field("record_kind", want.record_kind, out_tuser);
          check_field("final_result", want.final_result, out_tlast);
          check_field("status", want.status, out_tdata[2:0]);
          check_field("mode_code", want.mode_code, out_tdata[8:3]);
          check_field("body_len", want.body_len, out_tdata[16:9]);
          check_field("body_offset", want.body_offset, out_tdata[24:17]);
          check_field("page_count", want.page_count, out_tdata[29:25]);
          check_field("media_kind", want.media_kind, out_tdata[37:30]);
          check_field("dev_spec", want.dev_spec, out_tdata[45:38]);
          check_field("desc_len", want.desc_len, out_tdata[53:46]);
          check_field("block_total", want.block_total, out_tdata[77:54]);
          check_field("block_bytes", want.block_bytes, out_tdata[101:78]);
          check_field("padding", 24'd0, out_tdata[OUT_DATA_W-1:102]);
        end
      end
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    out_tready = 1'b0;
    clear_parser();

    // one byte only: too short
    list_draft = '{8'h00};
    flush_list(1'b0);
    // descriptor cut off on the last byte
    list_draft = '{8'hFF, 8'hFF, 8'hFF, 8'h02, 8'hAA};
    flush_list(1'b0);
    // full descriptor, then a zero-length page closing on the last byte
    list_draft = '{8'h00, 8'h01, 8'h02, 8'h08, 8'h5A, 8'hFF, 8'hFF, 8'hFF,
                   8'h5A, 8'h80, 8'h00, 8'h01, 8'hFF, 8'h00};
    flush_list(1'b0);
    // trailing code byte with no length byte
    list_draft = '{8'h00, 8'h10, 8'h20, 8'h00, 8'h3F};
    flush_list(1'b0);

    list_n = 0;
    while (list_bytes.size() < LIST_ITEMS) begin
      make_list(list_n == 8 || list_n == 24);
      flush_list(list_n % 12 == 5);
      list_n++;
    end
    total_bytes = list_bytes.size();

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    while (list_bytes.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("tb: errors");
    $finish;
  end

endmodule

[mode_select_list_parser.f]
rtl/mlsp_pkg.sv
rtl/mlsp_parser.sv
rtl/mlsp_out_fifo.sv
rtl/mode_select_list_parser.sv
tb/sv/tb.sv
